// ===== design/scdc_pkg.sv =====
// shared types and constants for the spi column display controller
package scdc_pkg;

   localparam int COLUMNS     = 148;
   localparam int ROWS        = 172;
   localparam int PAD_BOTTOM  = 16;
   localparam int PAD_TOP     = 17;
   localparam int STORE_DEPTH = COLUMNS * ROWS;

   localparam logic [2:0] FUNC_SPI    = 3'd0;
   localparam logic [2:0] FUNC_SELECT = 3'd1;
   localparam logic [2:0] FUNC_RESET  = 3'd2;
   localparam logic [2:0] FUNC_CLOCK  = 3'd3;
   localparam logic [2:0] FUNC_READ   = 3'd4;
   localparam logic [2:0] FUNC_ACK    = 3'd5;

   localparam logic [2:0] MODE_PROG   = 3'd0;
   localparam logic [2:0] MODE_CMD    = 3'd1;
   localparam logic [2:0] MODE_PARAM  = 3'd2;
   localparam logic [2:0] MODE_SCENE  = 3'd3;
   localparam logic [2:0] MODE_LINENO = 3'd4;
   localparam logic [2:0] MODE_DATA   = 3'd5;

   localparam logic [7:0] COLOR_BLACK = 8'h00;
   localparam logic [7:0] COLOR_RED   = 8'hC0;
   localparam logic [7:0] COLOR_GREEN = 8'h30;
   localparam logic [7:0] COLOR_BLUE  = 8'h0C;

   localparam logic [7:0] CMD_SET_PARAM   = 8'd1;
   localparam logic [7:0] CMD_DRAW_SCENE  = 8'd4;
   localparam logic [7:0] CMD_FRAME_BEGIN = 8'd0;
   localparam logic [7:0] CMD_FRAME_DATA  = 8'd1;
   localparam logic [7:0] CMD_FRAME_END   = 8'd2;

   localparam logic [7:0] SCENE_BLACK = 8'd0;
   localparam logic [7:0] SCENE_LOGO  = 8'd1;
   localparam logic [7:0] SCENE_GREEN = 8'd2;
   localparam logic [7:0] SCENE_BLUE  = 8'd3;

   localparam int LOGO_X = 8;
   localparam int LOGO_Y = 68;
   localparam int LOGO_W = 128;
   localparam int LOGO_H = 32;

   localparam logic [1:0] CSR_COMMAND_SET = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD   = 2'd1;

   // controller to datapath: one memory operation
   typedef struct packed {
      logic        wr_en;
      logic [14:0] wr_addr;
      logic [7:0]  wr_data;
      logic        rd_en;
      logic [14:0] rd_addr;
   } mem_cmd_type;

endpackage

// ===== design/scdc_rom.sv =====
// logo rom, 512 bytes, registered read
module scdc_rom (
   input  logic       clock,
   input  logic [8:0] addr,
   output logic [7:0] data
);
   logic [7:0] rom [0:511];
   logic [7:0] data_ff;
   assign rom = '{
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h38,8'h00,8'h00,8'h1c,8'h00,8'h00,8'h0e,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h38,8'h00,8'h00,8'h1c,8'h00,8'h00,8'h0e,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h38,8'h00,8'h00,8'h1c,8'h00,8'h00,8'h0e,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h38,8'h00,8'h00,8'h1c,8'h00,8'h00,8'h0e,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h38,8'h00,8'h00,8'h1c,8'h00,8'h00,8'h0e,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h38,8'h00,8'h00,8'h1c,8'h00,8'h00,8'h0e,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h38,8'h00,8'h00,8'h1c,8'h00,8'h00,8'h0e,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h07,8'h00,8'he0,8'h01,8'h38,8'h70,8'h00,8'h1c,8'h38,8'h00,8'h0e,8'hc0,8'h03,8'h00,
      8'h80,8'he3,8'h3f,8'h00,8'hfc,8'h0f,8'h38,8'hfe,8'h03,8'h1c,8'hff,8'h01,8'h0e,8'hf8,8'h1f,8'h00,
      8'h80,8'hf3,8'h7f,8'h00,8'hfe,8'h1f,8'h38,8'hff,8'h0f,8'h9c,8'hff,8'h07,8'h0e,8'hfc,8'h3f,8'h00,
      8'h80,8'h3b,8'hf0,8'h00,8'h0f,8'h3c,8'hb8,8'h03,8'h1f,8'hdc,8'h81,8'h0f,8'h0e,8'h1e,8'h78,8'h00,
      8'h80,8'h0f,8'he0,8'h81,8'h03,8'h78,8'hf8,8'h01,8'h1c,8'hfc,8'h00,8'h0e,8'h0e,8'h07,8'hf0,8'h00,
      8'h80,8'h0f,8'hc0,8'h83,8'h03,8'h70,8'hf8,8'h00,8'h3c,8'h7c,8'h00,8'h1e,8'h0e,8'h07,8'he0,8'h00,
      8'h80,8'h07,8'h80,8'hc3,8'h01,8'h70,8'h78,8'h00,8'h38,8'h3c,8'h00,8'h1c,8'h8e,8'h03,8'he0,8'h00,
      8'h80,8'h03,8'h80,8'hc3,8'h01,8'h7e,8'h38,8'h00,8'h30,8'h1c,8'h00,8'h18,8'h8e,8'h03,8'hfc,8'h00,
      8'h80,8'h03,8'h00,8'hc7,8'hc1,8'h1f,8'h38,8'h00,8'h70,8'h1c,8'h00,8'h38,8'h8e,8'h83,8'h3f,8'h00,
      8'h80,8'h03,8'h00,8'hc7,8'hf9,8'h03,8'h38,8'h00,8'h70,8'h1c,8'h00,8'h38,8'h8e,8'hf3,8'h07,8'h00,
      8'h80,8'h03,8'h00,8'hc7,8'h7f,8'h00,8'h38,8'h00,8'h70,8'h1c,8'h00,8'h38,8'h8e,8'hff,8'h00,8'h00,
      8'h80,8'h03,8'h00,8'hc7,8'h0f,8'h00,8'h38,8'h00,8'h70,8'h1c,8'h00,8'h38,8'h8e,8'h1f,8'h00,8'h00,
      8'h80,8'h03,8'h80,8'hc3,8'h01,8'h00,8'h38,8'h00,8'h30,8'h1c,8'h00,8'h18,8'h8e,8'h03,8'h00,8'h00,
      8'h80,8'h07,8'h80,8'hc3,8'h01,8'h00,8'h78,8'h00,8'h38,8'h3c,8'h00,8'h1c,8'h8e,8'h03,8'h00,8'h00,
      8'h80,8'h0f,8'hc0,8'h83,8'h03,8'h00,8'hf8,8'h00,8'h38,8'h7c,8'h00,8'h1c,8'h0e,8'h07,8'h00,8'h00,
      8'h80,8'h0f,8'hc0,8'h81,8'h07,8'h70,8'hf8,8'h01,8'h1c,8'hfc,8'h00,8'h0e,8'h0e,8'h0f,8'he0,8'h00,
      8'h80,8'h3f,8'hf0,8'h00,8'h0f,8'h78,8'hb8,8'h03,8'h1f,8'hdc,8'h81,8'h0f,8'h0e,8'h1e,8'hf0,8'h00,
      8'h80,8'hf3,8'h7f,8'h00,8'hfe,8'h3f,8'h38,8'hff,8'h07,8'h9c,8'hff,8'h03,8'h0e,8'hfc,8'h7f,8'h00,
      8'h80,8'he3,8'h3f,8'h00,8'hf8,8'h0f,8'h38,8'hfe,8'h03,8'h1c,8'hff,8'h01,8'h0e,8'hf0,8'h1f,8'h00,
      8'h80,8'h03,8'h07,8'h00,8'hc0,8'h01,8'h00,8'h70,8'h00,8'h00,8'h38,8'h00,8'h00,8'h80,8'h03,8'h00,
      8'h80,8'h03,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h80,8'h03,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h80,8'h03,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h80,8'h03,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h80,8'h03,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
   };
   always_ff @(posedge clock) begin
      data_ff <= rom[addr];
   end
   assign data = data_ff;
endmodule

// ===== design/scdc_datapath.sv =====
// frame store memory with one write and one registered read port
module scdc_datapath (
   input  logic                  clock,
   input  scdc_pkg::mem_cmd_type mem_cmd,
   output logic [7:0]            rd_data
);
   import scdc_pkg::*;
   logic [7:0] store [0:STORE_DEPTH-1];
   logic [7:0] rd_data_ff;
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         store[mem_cmd.wr_addr] <= mem_cmd.wr_data;
      end
      if (mem_cmd.rd_en) begin
         rd_data_ff <= store[mem_cmd.rd_addr];
      end
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== design/scdc_controller.sv =====
// event decoder, command state machine, fill sequencer and output register
module scdc_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_func,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_pin_level,
   input  logic [7:0]            req_read_column,
   input  logic [7:0]            req_read_row,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_busy_n_level,
   output logic                  rsp_prog_done_level,
   output logic [7:0]            rsp_pixel_byte,
   output logic                  rsp_frame_ready,
   output logic [31:0]           rsp_parameter_value,
   output scdc_pkg::mem_cmd_type mem_cmd,
   input  logic [7:0]            rd_data,
   output logic [8:0]            rom_addr,
   input  logic [7:0]            rom_data
);
   import scdc_pkg::*;

   localparam int DEPTH     = ROWS * COLUMNS;
   localparam int FIRST_TOP = ROWS + PAD_BOTTOM;
   localparam int LAST      = ROWS + PAD_BOTTOM + PAD_TOP - 1;
   localparam int LOGO_N    = LOGO_W * LOGO_H;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_FILL  = 3'd2;
   localparam logic [2:0] ST_LOGO  = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]  st_ff, st_in;
   logic [14:0] cnt_ff, cnt_in;
   logic [7:0]  color_ff, color_in;
   logic        logo_wr_ff, logo_wr_in;
   logic [11:0] logo_i_ff, logo_i_in;

   logic        cset_ff;
   logic [7:0]  thr_ff;
   logic [2:0]  mode_ff, mode_in;
   logic [31:0] param_ff, param_in;
   logic [2:0]  pcnt_ff, pcnt_in;
   logic [7:0]  col_ff, col_in;
   logic [8:0]  row_ff, row_in;
   logic        sel_ff, sel_in, clk_ff, clk_in;
   logic [7:0]  edge_ff, edge_in;
   logic        busy_ff, busy_in, pdone_ff, pdone_in, redraw_ff, redraw_in;
   logic        ovalid_ff, ovalid_in;
   logic [7:0]  pix_ff, pix_in;

   logic        accept;
   logic [14:0] logo_addr;
   logic        logo_in_range;
   logic [7:0]  logo_x, logo_y;
   logic        logo_bit;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (st_ff != ST_IDLE) || ovalid_ff;
   assign rsp_valid = ovalid_ff && (st_ff == ST_IDLE);

   // logo pixel under the registered rom read
   assign logo_x = 8'(LOGO_X + int'(logo_i_ff[6:0]));
   assign logo_y = 8'(LOGO_Y + int'(logo_i_ff[11:7]));
   assign logo_in_range = (int'(logo_x) < COLUMNS) && (int'(logo_y) < ROWS);
   assign logo_addr = 15'(int'(logo_y) * COLUMNS + int'(logo_x));
   assign logo_bit  = rom_data[logo_i_ff[2:0]];
   assign rom_addr  = logo_i_in[11:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cset_ff <= 1'b1;
         thr_ff  <= 8'd50;
      end else if (csr_write) begin
         case (csr_index)
            CSR_COMMAND_SET: cset_ff <= csr_data[0];
            CSR_THRESHOLD:   thr_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; color_in = color_ff;
      logo_wr_in = 1'b0; logo_i_in = logo_i_ff;
      mode_in = mode_ff; param_in = param_ff; pcnt_in = pcnt_ff;
      col_in = col_ff; row_in = row_ff; sel_in = sel_ff; clk_in = clk_ff;
      edge_in = edge_ff; busy_in = busy_ff; pdone_in = pdone_ff;
      redraw_in = redraw_ff; ovalid_in = ovalid_ff; pix_in = pix_ff;
      mem_cmd = '0;

      if (ovalid_ff && st_ff == ST_IDLE && !rsp_stall) begin
         ovalid_in = 1'b0;
      end

      case (st_ff)
         ST_CLEAR, ST_FILL: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = cnt_ff;
            mem_cmd.wr_data = color_ff;
            cnt_in = cnt_ff + 15'd1;
            if (int'(cnt_ff) == DEPTH - 1) begin
               st_in = ST_IDLE;
            end
         end
         ST_LOGO: begin
            // rom data of logo_i_ff is valid once logo_wr_ff is set
            if (logo_wr_ff) begin
               mem_cmd.wr_en   = logo_in_range;
               mem_cmd.wr_addr = logo_addr;
               mem_cmd.wr_data = logo_bit ? COLOR_RED : COLOR_BLACK;
               if (int'(logo_i_ff) == LOGO_N - 1) begin
                  st_in = ST_IDLE;
               end else begin
                  logo_i_in  = logo_i_ff + 12'd1;
                  logo_wr_in = 1'b1;
               end
            end else begin
               logo_wr_in = 1'b1;
            end
         end
         ST_READ: begin
            st_in = ST_OUT;
         end
         ST_OUT: begin
            pix_in = rd_data;
            st_in  = ST_IDLE;
         end
         default: begin
            if (accept) begin
               ovalid_in = 1'b1;
               pix_in    = 8'h00;
               case (req_func)
                  FUNC_SPI: begin
                     if (!sel_ff) begin
                        case (mode_ff)
                           MODE_CMD: begin
                              busy_in = 1'b1;
                              if (!cset_ff) begin
                                 if (req_data_byte == CMD_SET_PARAM) begin
                                    mode_in = MODE_PARAM; pcnt_in = 3'd0;
                                 end else if (req_data_byte == CMD_DRAW_SCENE) begin
                                    mode_in = MODE_SCENE;
                                 end else begin
                                    busy_in = 1'b0; mode_in = MODE_CMD; pcnt_in = 3'd0;
                                 end
                              end else begin
                                 if (req_data_byte == CMD_FRAME_BEGIN) begin
                                    busy_in = 1'b1;
                                 end else if (req_data_byte == CMD_FRAME_DATA) begin
                                    mode_in = MODE_LINENO;
                                 end else begin
                                    if (req_data_byte == CMD_FRAME_END) begin
                                       redraw_in = 1'b1;
                                    end
                                    busy_in = 1'b0; mode_in = MODE_CMD; pcnt_in = 3'd0;
                                 end
                              end
                           end
                           MODE_PARAM: begin
                              case (pcnt_ff[1:0])
                                 2'd0:    param_in[7:0]   = req_data_byte;
                                 2'd1:    param_in[15:8]  = req_data_byte;
                                 2'd2:    param_in[23:16] = req_data_byte;
                                 default: param_in[31:24] = req_data_byte;
                              endcase
                              pcnt_in = pcnt_ff + 3'd1;
                              if (pcnt_ff >= 3'd3) begin
                                 busy_in = 1'b0; mode_in = MODE_CMD; pcnt_in = 3'd0;
                              end
                           end
                           MODE_SCENE: begin
                              busy_in = 1'b0; mode_in = MODE_CMD; pcnt_in = 3'd0;
                              redraw_in = 1'b1;
                              cnt_in = '0;
                              case (req_data_byte)
                                 SCENE_BLACK: begin st_in = ST_FILL; color_in = COLOR_BLACK; end
                                 SCENE_GREEN: begin st_in = ST_FILL; color_in = COLOR_GREEN; end
                                 SCENE_BLUE:  begin st_in = ST_FILL; color_in = COLOR_BLUE;  end
                                 SCENE_LOGO:  begin st_in = ST_LOGO; logo_i_in = '0; end
                                 default: ;
                              endcase
                           end
                           MODE_LINENO: begin
                              col_in  = (int'(req_data_byte) >= COLUMNS) ? 8'd0 : req_data_byte;
                              row_in  = 9'd0;
                              mode_in = MODE_DATA;
                              busy_in = 1'b1;
                           end
                           MODE_DATA: begin
                              if (int'(row_ff) >= LAST) begin
                                 mode_in = MODE_LINENO;
                                 busy_in = 1'b0;
                              end else begin
                                 if (int'(row_ff) >= PAD_BOTTOM && int'(row_ff) < FIRST_TOP) begin
                                    mem_cmd.wr_en   = 1'b1;
                                    mem_cmd.wr_addr = 15'((FIRST_TOP - 1 - int'(row_ff))
                                                      * COLUMNS + int'(col_ff));
                                    mem_cmd.wr_data = req_data_byte;
                                 end
                                 row_in = row_ff + 9'd1;
                              end
                           end
                           default: ;
                        endcase
                     end
                  end
                  FUNC_SELECT: begin
                     sel_in = req_pin_level;
                     if (req_pin_level && mode_ff != MODE_PROG) begin
                        busy_in = 1'b0; mode_in = MODE_CMD; pcnt_in = 3'd0;
                     end
                  end
                  FUNC_RESET: begin
                     pdone_in = 1'b0;
                     if (!req_pin_level) begin
                        busy_in = 1'b1; edge_in = 8'd0; mode_in = MODE_PROG;
                     end
                  end
                  FUNC_CLOCK: begin
                     if (sel_ff) begin
                        edge_in = (req_pin_level && !clk_ff && edge_ff != 8'hFF)
                                  ? edge_ff + 8'd1 : edge_ff;
                        if (edge_in > thr_ff) begin
                           pdone_in = 1'b1;
                           if (mode_ff == MODE_PROG) begin
                              busy_in = 1'b0; mode_in = MODE_CMD; pcnt_in = 3'd0;
                           end
                        end
                     end
                     clk_in = req_pin_level;
                  end
                  FUNC_READ: begin
                     if (int'(req_read_column) < COLUMNS && int'(req_read_row) < ROWS) begin
                        mem_cmd.rd_en   = 1'b1;
                        mem_cmd.rd_addr = 15'(int'(req_read_row) * COLUMNS
                                          + int'(req_read_column));
                        st_in = ST_READ;
                     end
                  end
                  FUNC_ACK: redraw_in = 1'b0;
                  default: ;
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR; cnt_ff <= '0; color_ff <= COLOR_BLACK;
         logo_wr_ff <= 1'b0; logo_i_ff <= '0;
         mode_ff <= MODE_PROG; param_ff <= '0; pcnt_ff <= '0;
         col_ff <= '0; row_ff <= '0; sel_ff <= 1'b0; clk_ff <= 1'b0;
         edge_ff <= '0; busy_ff <= 1'b0; pdone_ff <= 1'b0; redraw_ff <= 1'b0;
         ovalid_ff <= 1'b0; pix_ff <= '0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; color_ff <= color_in;
         logo_wr_ff <= logo_wr_in; logo_i_ff <= logo_i_in;
         mode_ff <= mode_in; param_ff <= param_in; pcnt_ff <= pcnt_in;
         col_ff <= col_in; row_ff <= row_in; sel_ff <= sel_in; clk_ff <= clk_in;
         edge_ff <= edge_in; busy_ff <= busy_in; pdone_ff <= pdone_in;
         redraw_ff <= redraw_in; ovalid_ff <= ovalid_in; pix_ff <= pix_in;
      end
   end

   assign rsp_busy_n_level    = busy_ff;
   assign rsp_prog_done_level = pdone_ff;
   assign rsp_pixel_byte      = pix_ff;
   assign rsp_frame_ready     = redraw_ff;
   assign rsp_parameter_value = param_ff;
endmodule

// ===== design/spi_column_display_controller_unit.sv =====
// top level of the spi column display controller
// Usage: each req_ transfer carries one pin or bus event (req_func selects spi byte,
// select, reset pin, clock pin, pixel read or frame acknowledge). Each event gives
// exactly one rsp_ transfer with the line levels, pixel value and last parameter.
// Most events are answered in the cycle after they are taken; a pixel read passes
// the registered frame store read and the ST_READ and ST_OUT states first. The output
// register must drain before the next event is taken.
// Scene fills write one frame store location per cycle, over the whole store for a
// solid fill or over the logo area for the logo; req_stall is high meanwhile.
// Reset: synchronous, active high; the block then runs a clearing pass over the
// whole frame store with req_stall high. csr_ writes are taken at any time,
// registers reset to command set 1 and threshold 50.
// When rsp_stall is high the result holds and req_stall stays high.
module spi_column_display_controller_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_data_byte,
   input  logic        req_pin_level,
   input  logic [7:0]  req_read_column,
   input  logic [7:0]  req_read_row,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_busy_n_level,
   output logic        rsp_prog_done_level,
   output logic [7:0]  rsp_pixel_byte,
   output logic        rsp_frame_ready,
   output logic [31:0] rsp_parameter_value
);
   import scdc_pkg::*;
   mem_cmd_type mem_cmd;
   logic [7:0]  rd_data, rom_data;
   logic [8:0]  rom_addr;

   scdc_controller u_ctrl (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_valid, .req_stall, .req_func, .req_data_byte, .req_pin_level,
      .req_read_column, .req_read_row, .rsp_valid, .rsp_stall,
      .rsp_busy_n_level, .rsp_prog_done_level, .rsp_pixel_byte,
      .rsp_frame_ready, .rsp_parameter_value,
      .mem_cmd, .rd_data, .rom_addr, .rom_data
   );

   scdc_datapath u_dp (
      .clock, .mem_cmd, .rd_data
   );

   scdc_rom u_rom (
      .clock, .addr(rom_addr), .data(rom_data)
   );
endmodule
